// ----- hw/rtl/tld_pkg.sv -----
`default_nettype none
package tld_pkg;

  localparam int LINE_MAX_DEF = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_FLAGS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FLAGS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_FLAGS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_CHARS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDIT_CHARS   = 3'd4;

  localparam logic [3:0]  INPUT_FLAGS_RST  = 4'd4;
  localparam logic [2:0]  OUTPUT_FLAGS_RST = 3'd5;
  localparam logic [6:0]  LOCAL_FLAGS_RST  = 7'd95;
  localparam logic [23:0] SIGNAL_CHARS_RST = 24'h1A1C03;
  localparam logic [31:0] EDIT_CHARS_RST   = 32'h15177F04;

  // result kinds
  localparam logic [2:0] KIND_TX     = 3'd0;
  localparam logic [2:0] KIND_RUBOUT = 3'd1;
  localparam logic [2:0] KIND_LINE   = 3'd2;
  localparam logic [2:0] KIND_SIGNAL = 3'd3;
  localparam logic [2:0] KIND_CLOSED = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_AT    = 8'h40;

  // decoded actions for one item
  localparam logic [3:0] ACT_TX     = 4'd0;
  localparam logic [3:0] ACT_SIG    = 4'd1;
  localparam logic [3:0] ACT_CLOSE  = 4'd2;
  localparam logic [3:0] ACT_DROP   = 4'd3;
  localparam logic [3:0] ACT_ERASE  = 4'd4;
  localparam logic [3:0] ACT_WERASE = 4'd5;
  localparam logic [3:0] ACT_KILL   = 4'd6;
  localparam logic [3:0] ACT_CHAR   = 4'd7;
  localparam logic [3:0] ACT_NL     = 4'd8;

  typedef struct packed {
    logic [3:0] act;
    logic [7:0] chr;
    logic [1:0] code;
  } tld_act_t;

  typedef struct packed {
    logic [3:0]  input_flags;
    logic [6:0]  local_flags;
    logic [23:0] signal_chars;
    logic [31:0] edit_chars;
  } tld_cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tld_if.sv -----
`default_nettype none
interface tld_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface tld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;
  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tld_decode.sv -----
`default_nettype none
module tld_decode (
  input  wire logic            func,
  input  wire logic [7:0]      data_byte,
  input  wire logic            len_zero,
  input  wire tld_pkg::tld_cfg_t cfg,
  output tld_pkg::tld_act_t    act
);
  import tld_pkg::*;

  logic       isig, canon;
  logic [7:0] b1, b2, b3, b4;

  always_comb begin
    isig = cfg.local_flags[0];
    canon = cfg.local_flags[1];
    act = '{act: ACT_DROP, chr: data_byte, code: 2'd0};
    b1 = data_byte;
    if (canon && data_byte == cfg.edit_chars[7:0] && !len_zero) b1 = CH_CR;
    b2 = (cfg.input_flags[0] && b1 == CH_LF) ? CH_CR : b1;
    b3 = (cfg.input_flags[2] && b2 == CH_CR) ? CH_LF : b2;
    b4 = (cfg.input_flags[3] && b3 >= 8'h41 && b3 <= 8'h5A) ? b3 + 8'h20 : b3;
    if (func) begin
      act.act = ACT_TX;
    end else if (isig && data_byte == cfg.signal_chars[7:0]) begin
      act.act = ACT_SIG;
      act.code = 2'd0;
    end else if (isig && data_byte == cfg.signal_chars[15:8]) begin
      act.act = ACT_SIG;
      act.code = 2'd1;
    end else if (canon && data_byte == cfg.edit_chars[7:0] && len_zero) begin
      act.act = ACT_CLOSE;
    end else if (isig && b1 == cfg.signal_chars[23:16]) begin
      act.act = ACT_SIG;
      act.code = 2'd2;
      act.chr = b1;
    end else if (cfg.input_flags[1] && b2 == CH_CR) begin
      act.act = ACT_DROP;
    end else if (canon && cfg.local_flags[3] && b3 == cfg.edit_chars[15:8]) begin
      act.act = ACT_ERASE;
    end else if (canon && b3 == cfg.edit_chars[23:16]) begin
      act.act = ACT_WERASE;
    end else if (canon && cfg.local_flags[4] && b3 == cfg.edit_chars[31:24]) begin
      act.act = ACT_KILL;
    end else if (b4 == CH_LF) begin
      act.act = ACT_NL;
      act.chr = CH_LF;
    end else begin
      act.act = ACT_CHAR;
      act.chr = b4;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tty_line_discipline_top.sv -----
`default_nettype none
// An accepted item goes through decode, generate and stage to its first result on out_ch;
// echo and signal results then follow at about one result per cycle while out_ch is not
// stalled, each delivered line byte takes a read and an emit state (line store read port),
// and word erase scans the store one byte at a time in a read and a check state. One item at
// a time: the next is taken in the cycle after its last result enters the output register.
// Reset (rst_n low, synchronous): registers to defaults, line empty, no result pending.
module tty_line_discipline_top #(
  parameter int LINE_MAX = tld_pkg::LINE_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  tld_in_if.sink                           in_ch,
  tld_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tld_pkg::CFG_W-1:0]   cfg_data
);
  import tld_pkg::*;

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(LINE_MAX - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SIG0 = 4'd2;
  localparam logic [3:0] S_SIG1 = 4'd3;
  localparam logic [3:0] S_SIG2 = 4'd4;
  localparam logic [3:0] S_ECHO = 4'd5;
  localparam logic [3:0] S_ONE  = 4'd6;
  localparam logic [3:0] S_D_RD = 4'd7;
  localparam logic [3:0] S_D_EM = 4'd8;
  localparam logic [3:0] S_W_RD = 4'd9;
  localparam logic [3:0] S_W_CK = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]  input_flags_r;
  logic [2:0]  output_flags_r;
  logic [6:0]  local_flags_r;
  logic [23:0] signal_chars_r;
  logic [31:0] edit_chars_r;
  tld_cfg_t    cfg;

  logic [3:0]    st_r;
  logic          func_r;
  logic [7:0]    byte_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] idx_r;
  logic [LW-1:0] n_r;
  logic [7:0]    x_r;
  logic [7:0]    ch_r;
  logic          deliv_r;
  logic          xcr_r;
  logic [2:0]    one_kind_r;
  logic [7:0]    one_val_r;
  logic          one_deliv_r;

  logic          pend_v_r;
  logic [2:0]    pend_kind_r;
  logic [7:0]    pend_val_r;
  logic          out_v_r;
  logic [2:0]    out_kind_r;
  logic [7:0]    out_val_r;
  logic          out_last_r;

  logic [7:0]    mem [LINE_MAX];
  logic [7:0]    rd_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  tld_act_t      act;
  logic          out_free, slot_ok, g_req, g_fire;
  logic [2:0]    g_kind;
  logic [7:0]    g_val;
  logic [7:0]    xsrc, xpb;
  logic          xcrlf, xdone;
  logic [LW-1:0] len_m1;

  assign cfg = '{input_flags: input_flags_r, local_flags: local_flags_r,
                 signal_chars: signal_chars_r, edit_chars: edit_chars_r};

  tld_decode u_dec (
    .func      (func_r),
    .data_byte (byte_r),
    .len_zero  (len_r == '0),
    .cfg       (cfg),
    .act       (act)
  );

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.value = out_val_r;
  assign out_ch.last  = out_last_r;

  assign len_m1   = len_r - LW'(1);
  assign out_free = !out_v_r || out_ch.ready;
  assign slot_ok  = !pend_v_r || out_free;
  assign g_fire   = g_req && slot_ok;

  // transmit post-processing
  always_comb begin
    case (st_r)
      S_SIG0:  xsrc = CH_CARET;
      S_SIG1:  xsrc = CH_AT + ch_r;
      S_SIG2:  xsrc = CH_LF;
      default: xsrc = x_r;
    endcase
    xpb = xsrc;
    if (output_flags_r[0] && output_flags_r[1] && xsrc >= 8'h61 && xsrc <= 8'h7A)
      xpb = xsrc - 8'h20;
    xcrlf = output_flags_r[0] && output_flags_r[2] && xpb == CH_LF && !xcr_r;
    xdone = g_fire && !xcrlf;
  end

  always_comb begin
    g_req = 1'b0;
    g_kind = KIND_TX;
    g_val = xpb;
    case (st_r)
      S_SIG0, S_SIG1, S_SIG2, S_ECHO: begin
        g_req = 1'b1;
        g_val = xcrlf ? CH_CR : xpb;
      end
      S_ONE: begin
        g_req = 1'b1;
        g_kind = one_kind_r;
        g_val = one_val_r;
      end
      S_D_EM: begin
        g_req = 1'b1;
        g_kind = KIND_LINE;
        g_val = rd_q;
      end
      default: g_req = 1'b0;
    endcase
  end

  // line store write at decode
  always_comb begin
    we = 1'b0;
    waddr = len_r[AW-1:0];
    wdata = act.chr;
    if (st_r == S_DEC) begin
      case (act.act)
        ACT_CLOSE: begin
          we = 1'b1;
          waddr = '0;
          wdata = CH_LF;
        end
        ACT_CHAR: we = (len_r < LEN_FULL);
        ACT_NL:   we = 1'b1;
        default:  we = 1'b0;
      endcase
    end
    raddr = (st_r == S_W_RD) ? len_m1[AW-1:0] : idx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_flags_r  <= INPUT_FLAGS_RST;
      output_flags_r <= OUTPUT_FLAGS_RST;
      local_flags_r  <= LOCAL_FLAGS_RST;
      signal_chars_r <= SIGNAL_CHARS_RST;
      edit_chars_r   <= EDIT_CHARS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_FLAGS:  input_flags_r  <= cfg_data[3:0];
        REG_OUTPUT_FLAGS: output_flags_r <= cfg_data[2:0];
        REG_LOCAL_FLAGS:  local_flags_r  <= cfg_data[6:0];
        REG_SIGNAL_CHARS: signal_chars_r <= cfg_data[23:0];
        REG_EDIT_CHARS:   edit_chars_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // result staging: the held result goes out once the next one or the end is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (g_fire) begin
        if (pend_v_r) begin
          out_v_r    <= 1'b1;
          out_kind_r <= pend_kind_r;
          out_val_r  <= pend_val_r;
          out_last_r <= 1'b0;
        end
        pend_v_r    <= 1'b1;
        pend_kind_r <= g_kind;
        pend_val_r  <= g_val;
      end else if (st_r == S_DONE && pend_v_r && out_free) begin
        out_v_r    <= 1'b1;
        out_kind_r <= pend_kind_r;
        out_val_r  <= pend_val_r;
        out_last_r <= 1'b1;
        pend_v_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      len_r <= '0;
      xcr_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r <= in_ch.func;
            byte_r <= in_ch.data_byte;
            st_r   <= S_DEC;
          end
        end
        S_DEC: begin
          idx_r <= '0;
          case (act.act)
            ACT_TX: begin
              x_r <= act.chr;
              deliv_r <= 1'b0;
              st_r <= S_ECHO;
            end
            ACT_SIG: begin
              ch_r <= act.chr;
              one_kind_r <= KIND_SIGNAL;
              one_val_r <= {6'd0, act.code};
              one_deliv_r <= 1'b0;
              st_r <= local_flags_r[6] ? S_SIG0 : S_ONE;
            end
            ACT_CLOSE: begin
              len_r <= LW'(1);
              one_kind_r <= KIND_CLOSED;
              one_val_r <= 8'd0;
              one_deliv_r <= 1'b1;
              st_r <= S_ONE;
            end
            ACT_ERASE: begin
              if (len_r != '0) begin
                len_r <= len_m1;
                one_kind_r <= KIND_RUBOUT;
                one_val_r <= 8'd1;
                one_deliv_r <= 1'b0;
                st_r <= S_ONE;
              end else begin
                st_r <= S_DONE;
              end
            end
            ACT_WERASE: begin
              n_r <= '0;
              st_r <= S_W_RD;
            end
            ACT_KILL: begin
              if (len_r != '0) begin
                len_r <= '0;
                one_kind_r <= KIND_RUBOUT;
                one_val_r <= 8'(len_r);
                one_deliv_r <= 1'b0;
                st_r <= S_ONE;
              end else begin
                st_r <= S_DONE;
              end
            end
            ACT_CHAR: begin
              if (len_r >= LEN_FULL) begin
                st_r <= local_flags_r[1] ? S_DONE : S_D_RD;
              end else begin
                len_r <= len_r + LW'(1);
                if (local_flags_r[1] && local_flags_r[2]) begin
                  x_r <= act.chr;
                  deliv_r <= 1'b0;
                  st_r <= S_ECHO;
                end else begin
                  st_r <= local_flags_r[1] ? S_DONE : S_D_RD;
                end
              end
            end
            ACT_NL: begin
              len_r <= len_r + LW'(1);
              if (local_flags_r[1] && (local_flags_r[2] || local_flags_r[5])) begin
                x_r <= CH_LF;
                deliv_r <= 1'b1;
                st_r <= S_ECHO;
              end else begin
                st_r <= S_D_RD;
              end
            end
            default: st_r <= S_DONE;
          endcase
        end
        S_SIG0, S_SIG1, S_SIG2, S_ECHO: begin
          if (g_fire) xcr_r <= xcrlf;
          if (xdone) begin
            case (st_r)
              S_SIG0:  st_r <= S_SIG1;
              S_SIG1:  st_r <= S_SIG2;
              S_SIG2:  st_r <= S_ONE;
              default: st_r <= deliv_r ? S_D_RD : S_DONE;
            endcase
          end
        end
        S_ONE: begin
          if (g_fire) st_r <= one_deliv_r ? S_D_RD : S_DONE;
        end
        S_D_RD: st_r <= S_D_EM;
        S_D_EM: begin
          if (g_fire) begin
            if (idx_r + LW'(1) == len_r) begin
              len_r <= '0;
              st_r <= S_DONE;
            end else begin
              idx_r <= idx_r + LW'(1);
              st_r <= S_D_RD;
            end
          end
        end
        S_W_RD: begin
          if (len_r == '0) begin
            one_kind_r <= KIND_RUBOUT;
            one_val_r <= 8'(n_r);
            one_deliv_r <= 1'b0;
            st_r <= (n_r != '0) ? S_ONE : S_DONE;
          end else begin
            len_r <= len_m1;
            n_r <= n_r + LW'(1);
            st_r <= S_W_CK;
          end
        end
        S_W_CK: begin
          if (rd_q == CH_SPACE) begin
            one_kind_r <= KIND_RUBOUT;
            one_val_r <= 8'(n_r);
            one_deliv_r <= 1'b0;
            st_r <= S_ONE;
          end else begin
            st_r <= S_W_RD;
          end
        end
        S_DONE: begin
          if (!pend_v_r || out_free) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
